FILE: rtl/sks_pkg.sv
// Package for the skipped key store: sizes, request codes, state encoding
// and the packed layouts of the entry and epoch slot memories.
// No dependencies.
package sks_pkg;

    localparam int MaxEntries = 64;
    localparam int KeyBits    = 256;
    localparam int IdxW       = $clog2(MaxEntries);
    localparam int CntW       = IdxW + 1;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_READ   = 2'd3
    } t_req;

    localparam logic [1:0] ADDR_AGE_LIMIT = 2'd0;
    localparam logic [31:0] AGE_LIMIT_RST = 32'd1000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_W_RD,
        ST_W_EV,
        ST_W_SL,
        ST_S_SCAN,
        ST_S_INS,
        ST_R_RD,
        ST_R_OUT
    } t_state;

    typedef struct packed {
        logic [KeyBits-1:0] key;
        logic [31:0]        num;
        logic [31:0]        age;
        logic [IdxW-1:0]    ep;
    } t_entry;

    typedef struct packed {
        logic [CntW-1:0]    rc;
        logic [KeyBits-1:0] hk;
    } t_slot;

endpackage

FILE: rtl/skipped_key_store_unit.sv
// Skipped key store top level: entry memory, epoch slot memory and the
// sequencer that walks, compacts and interns. Depends on sks_pkg.
//
// Out-of-range remove/read and a tick on an empty store answer straight from
// idle; read fetches the entry; remove and tick walk the entries, reading each
// and releasing the slot of each one dropped; insert scans the slots, stopping
// at the first matching slot, after first evicting the oldest entry when full.
// One request at a time; results are a one-cycle o_valid strobe, no stall.
// Synchronous active-low reset empties the store and sets age_limit to 1000.
module skipped_key_store_unit
    import sks_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [1:0]   i_req_type,
    input  logic [5:0]   i_entry_index,
    input  logic [31:0]  i_msg_number,
    input  logic [63:0]  i_hk_word0,
    input  logic [63:0]  i_hk_word1,
    input  logic [63:0]  i_hk_word2,
    input  logic [63:0]  i_hk_word3,
    input  logic [63:0]  i_mk_word0,
    input  logic [63:0]  i_mk_word1,
    input  logic [63:0]  i_mk_word2,
    input  logic [63:0]  i_mk_word3,
    output logic         o_valid,
    output logic         o_status,
    output logic [6:0]   o_entries_held,
    output logic [5:0]   o_epoch_slot_used,
    output logic         o_evicted_oldest,
    output logic [6:0]   o_expired_count,
    output logic [31:0]  o_read_msg_number,
    output logic [63:0]  o_read_mk_word0,
    output logic [63:0]  o_read_mk_word1,
    output logic [63:0]  o_read_mk_word2,
    output logic [63:0]  o_read_mk_word3,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // memories
    t_entry r_emem [MaxEntries];
    t_slot  r_smem [MaxEntries];
    logic [MaxEntries-1:0] r_sval;

    logic            e_we, e_re, s_we, s_re;
    logic [IdxW-1:0] e_wa, e_ra, s_wa, s_ra;
    t_entry          e_wd, r_erd;
    t_slot           s_wd, r_srd;
    logic            r_srv;

    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic [IdxW-1:0] r_didx, n_didx;
    logic [31:0]  r_num, n_num;
    logic [KeyBits-1:0] r_hk, n_hk, r_mk, n_mk;
    logic [CntW-1:0] r_cnt, n_cnt, r_rp, n_rp, r_wp, n_wp, r_exp, n_exp;
    logic [31:0]  r_rcv, n_rcv, r_age_limit;
    logic         r_evict, n_evict;
    logic [CntW-1:0] r_sk, n_sk, r_vac, n_vac, r_frc, n_frc;
    logic [IdxW-1:0] r_se, n_se, r_fs, n_fs;
    logic         r_sv, n_sv;

    logic         r_ov, n_ov, r_ost, n_ost, r_oev, n_oev;
    logic [6:0]   r_oheld, n_oheld, r_oexp, n_oexp;
    logic [5:0]   r_oep, n_oep;
    logic [31:0]  r_onum, n_onum;
    logic [KeyBits-1:0] r_okey, n_okey;

    logic            walk_done;
    logic            drop;
    logic [CntW-1:0] rc_eff;
    logic [IdxW-1:0] vac_now;

    // entry memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (e_we) r_emem[e_wa] <= e_wd;
        if (e_re) r_erd <= r_emem[e_ra];
    end

    // slot memory; valid bits make unwritten slots read as free
    always_ff @(posedge i_clk) begin
        if (s_we) r_smem[s_wa] <= s_wd;
        if (s_re) r_srd <= r_smem[s_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sval <= '0;
            r_srv  <= 1'b0;
        end else begin
            if (s_we) r_sval[s_wa] <= 1'b1;
            if (s_re) r_srv <= r_sval[s_ra];
        end
    end

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_AGE_LIMIT) ? r_age_limit : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_limit <= AGE_LIMIT_RST;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_AGE_LIMIT) begin
            r_age_limit <= pwdata;
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_rcv   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rcv   <= n_rcv;
            r_ov    <= n_ov;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_didx  <= n_didx;
        r_num   <= n_num;
        r_hk    <= n_hk;
        r_mk    <= n_mk;
        r_rp    <= n_rp;
        r_wp    <= n_wp;
        r_exp   <= n_exp;
        r_evict <= n_evict;
        r_sk    <= n_sk;
        r_vac   <= n_vac;
        r_frc   <= n_frc;
        r_se    <= n_se;
        r_fs    <= n_fs;
        r_sv    <= n_sv;
        r_ost   <= n_ost;
        r_oev   <= n_oev;
        r_oheld <= n_oheld;
        r_oexp  <= n_oexp;
        r_oep   <= n_oep;
        r_onum  <= n_onum;
        r_okey  <= n_okey;
    end

    assign rc_eff  = r_srv ? r_srd.rc : '0;
    assign vac_now = (r_vac[IdxW] && rc_eff == '0) ? r_se : r_vac[IdxW-1:0];

    // next state, memory control and result
    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_didx  = r_didx;
        n_num   = r_num;
        n_hk    = r_hk;
        n_mk    = r_mk;
        n_cnt   = r_cnt;
        n_rcv   = r_rcv;
        n_rp    = r_rp;
        n_wp    = r_wp;
        n_exp   = r_exp;
        n_evict = r_evict;
        n_sk    = r_sk;
        n_vac   = r_vac;
        n_frc   = r_frc;
        n_se    = r_se;
        n_fs    = r_fs;
        n_sv    = r_sv;
        n_ov    = 1'b0;
        n_ost   = 1'b0;
        n_oev   = 1'b0;
        n_oheld = r_cnt;
        n_oexp  = '0;
        n_oep   = '0;
        n_onum  = '0;
        n_okey  = '0;
        e_we = 1'b0; e_re = 1'b0; e_wa = '0; e_ra = '0; e_wd = r_erd;
        s_we = 1'b0; s_re = 1'b0; s_wa = '0; s_ra = '0; s_wd = r_srd;
        walk_done = 1'b0;
        drop      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req  = t_req'(i_req_type);
                    n_didx = i_entry_index;
                    n_num  = i_msg_number;
                    n_hk   = {i_hk_word3, i_hk_word2, i_hk_word1, i_hk_word0};
                    n_mk   = {i_mk_word3, i_mk_word2, i_mk_word1, i_mk_word0};
                    n_exp  = '0;
                    n_sk   = '0;
                    n_sv   = 1'b0;
                    n_vac  = CntW'(MaxEntries);
                    n_evict = 1'b0;
                    unique case (t_req'(i_req_type))
                        REQ_INSERT: begin
                            if (r_cnt == CntW'(MaxEntries)) begin
                                n_evict = 1'b1;
                                n_didx  = '0;
                                n_rp    = '0;
                                n_wp    = '0;
                                n_state = ST_W_RD;
                            end else begin
                                n_state = ST_S_SCAN;
                            end
                        end
                        REQ_REMOVE: begin
                            if ({1'b0, i_entry_index} >= r_cnt) begin
                                n_ov  = 1'b1;
                                n_ost = 1'b1;
                            end else begin
                                n_rp    = {1'b0, i_entry_index};
                                n_wp    = {1'b0, i_entry_index};
                                n_state = ST_W_RD;
                            end
                        end
                        REQ_TICK: begin
                            n_rcv = r_rcv + 32'd1;
                            n_rp  = '0;
                            n_wp  = '0;
                            if (r_cnt == '0) n_ov = 1'b1;
                            else             n_state = ST_W_RD;
                        end
                        default: begin
                            if ({1'b0, i_entry_index} >= r_cnt) begin
                                n_ov  = 1'b1;
                                n_ost = 1'b1;
                            end else begin
                                n_state = ST_R_RD;
                            end
                        end
                    endcase
                end
            end
            // fetch the next entry of the walk
            ST_W_RD: begin
                e_re    = 1'b1;
                e_ra    = r_rp[IdxW-1:0];
                n_state = ST_W_EV;
            end
            // keep the entry, or fetch its slot for release
            ST_W_EV: begin
                if (r_req == REQ_TICK) drop = (r_rcv - r_erd.age) >= r_age_limit;
                else                   drop = (r_rp == {1'b0, r_didx});
                if (drop) begin
                    s_re    = 1'b1;
                    s_ra    = r_erd.ep;
                    n_state = ST_W_SL;
                end else begin
                    e_we = 1'b1;
                    e_wa = r_wp[IdxW-1:0];
                    e_wd = r_erd;
                    n_wp = r_wp + 1'b1;
                    n_rp = r_rp + 1'b1;
                    if (n_rp == r_cnt) walk_done = 1'b1;
                    else               n_state = ST_W_RD;
                end
            end
            // drop one reference; free the slot when it reaches zero
            ST_W_SL: begin
                if (rc_eff != '0) begin
                    s_we = 1'b1;
                    s_wa = r_erd.ep;
                    s_wd.rc = rc_eff - 1'b1;
                    s_wd.hk = (rc_eff == CntW'(1)) ? '0 : r_srd.hk;
                end
                n_exp = r_exp + 1'b1;
                n_rp  = r_rp + 1'b1;
                if (n_rp == r_cnt) walk_done = 1'b1;
                else               n_state = ST_W_RD;
            end
            // stream slot reads, compare one slot per cycle
            ST_S_SCAN: begin
                if (!r_sk[IdxW]) begin
                    s_re = 1'b1;
                    s_ra = r_sk[IdxW-1:0];
                    n_sk = r_sk + 1'b1;
                    n_se = r_sk[IdxW-1:0];
                    n_sv = 1'b1;
                end else begin
                    n_sv = 1'b0;
                end
                if (r_sv) begin
                    n_vac = {1'b0, vac_now};
                    if (r_vac[IdxW] && rc_eff == '0) n_vac = {1'b0, r_se};
                    else                              n_vac = r_vac;
                    if (rc_eff != '0 && r_srd.hk == r_hk) begin
                        n_fs    = r_se;
                        n_frc   = rc_eff;
                        n_state = ST_S_INS;
                    end else if (r_se == IdxW'(MaxEntries - 1)) begin
                        n_fs    = vac_now;
                        n_frc   = '0;
                        n_state = ST_S_INS;
                    end
                end
            end
            // append the entry and take a reference on its slot
            ST_S_INS: begin
                s_we    = 1'b1;
                s_wa    = r_fs;
                s_wd.rc = r_frc + 1'b1;
                s_wd.hk = r_hk;
                e_we     = 1'b1;
                e_wa     = r_cnt[IdxW-1:0];
                e_wd.key = r_mk;
                e_wd.num = r_num;
                e_wd.age = r_rcv;
                e_wd.ep  = r_fs;
                n_cnt   = r_cnt + 1'b1;
                n_ov    = 1'b1;
                n_oheld = n_cnt;
                n_oep   = r_fs;
                n_oev   = r_evict;
                n_state = ST_IDLE;
            end
            ST_R_RD: begin
                e_re    = 1'b1;
                e_ra    = r_didx;
                n_state = ST_R_OUT;
            end
            ST_R_OUT: begin
                n_ov    = 1'b1;
                n_oep   = r_erd.ep;
                n_onum  = r_erd.num;
                n_okey  = r_erd.key;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase

        // close the walk and hand over to the next step
        if (walk_done) begin
            n_cnt = n_wp;
            case (r_req)
                REQ_INSERT: n_state = ST_S_SCAN;
                REQ_TICK: begin
                    n_ov    = 1'b1;
                    n_oheld = n_wp;
                    n_oexp  = n_exp;
                    n_state = ST_IDLE;
                end
                default: begin
                    n_ov    = 1'b1;
                    n_oheld = n_wp;
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    assign busy              = (r_state != ST_IDLE);
    assign o_valid           = r_ov;
    assign o_status          = r_ost;
    assign o_entries_held    = r_oheld;
    assign o_epoch_slot_used = r_oep;
    assign o_evicted_oldest  = r_oev;
    assign o_expired_count   = r_oexp;
    assign o_read_msg_number = r_onum;
    assign o_read_mk_word0   = r_okey[63:0];
    assign o_read_mk_word1   = r_okey[127:64];
    assign o_read_mk_word2   = r_okey[191:128];
    assign o_read_mk_word3   = r_okey[255:192];

endmodule

FILE: rtl/sks_checker.sv
// Port-level checker for the skipped key store, bound to the top level.
// Depends only on the top-level ports.
module sks_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic       o_status,
    input logic [6:0] o_entries_held,
    input logic       o_evicted_oldest,
    input logic [6:0] o_expired_count
);

    // no result while a request is still at work
    a_no_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid) else $error("result strobe while busy");

    // an accepted request either runs or answers at once
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid)) else $error("request lost");

    // finishing a request always gives a result
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_valid) else $error("no result");

    // counts stay within the store size
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entries_held <= 7'd64 && o_expired_count <= 7'd64))
        else $error("count out of range");

    // a flagged request reports no eviction and no expired entries
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (!o_evicted_oldest && o_expired_count == 7'd0))
        else $error("flagged result with side fields");

endmodule

bind skipped_key_store_unit sks_checker u_sks_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_status         (o_status),
    .o_entries_held   (o_entries_held),
    .o_evicted_oldest (o_evicted_oldest),
    .o_expired_count  (o_expired_count)
);
